FILE: hdl/word_checksum_frame_builder_macros.svh
// assertion macros shared by the checker of the frame builder
// no dependencies; include guarded
`ifndef WORD_CHECKSUM_FRAME_BUILDER_MACROS_SVH
`define WORD_CHECKSUM_FRAME_BUILDER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define WCFB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wcfb check failed");

// next-cycle implication, disabled while in reset
`define WCFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wcfb check failed");

// next-cycle implication that also holds across reset
`define WCFB_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("wcfb check failed");

`endif

FILE: hdl/wcfb_pkg.sv
// types and constants of the word checksum frame builder
// no dependencies; used by every module of the block
package wcfb_pkg;

    // input item
    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] word_count;
        logic [15:0] data_word;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_last;
        logic [1:0] status;
    } t_out_item;

    // configuration registers
    typedef struct packed {
        logic [7:0]  address_byte;
        logic [7:0]  message_type;
        logic [15:0] attribute_word;
        logic        length_check_enable;
    } t_cfg;

    // one job for the serialiser: which parts of a frame to send, and their words
    typedef struct packed {
        logic        err;
        logic        has_hdr;
        logic        has_data;
        logic        has_csum;
        logic [1:0]  status;
        logic [15:0] len;
        logic [15:0] id;
        logic [15:0] seq;
        logic [15:0] attr;
        logic [15:0] data;
        logic [15:0] csum;
    } t_job;

    // opcodes
    localparam logic [1:0] OP_START     = 2'd0;
    localparam logic [1:0] OP_WORD      = 2'd1;
    localparam logic [1:0] OP_HEARTBEAT = 2'd2;
    localparam logic [1:0] OP_NONE      = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FRAME = 2'd1;
    localparam logic [1:0] ST_ABANDON  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ADDRESS   = 2'd0;
    localparam logic [1:0] CFG_TYPE      = 2'd1;
    localparam logic [1:0] CFG_ATTRIBUTE = 2'd2;
    localparam logic [1:0] CFG_LEN_CHECK = 2'd3;

    // frame constants
    localparam logic [7:0]  HDR_BYTE       = 8'hAA;
    localparam logic [7:0]  HEARTBEAT_TYPE = 8'h0E;
    localparam logic [12:0] FIXED_WORDS    = 13'd3;

    // byte positions within a full frame
    localparam logic [3:0] IDX_FIRST   = 4'd0;
    localparam logic [3:0] IDX_HDR_END = 4'd11;
    localparam logic [3:0] IDX_DATA_HI = 4'd12;
    localparam logic [3:0] IDX_DATA_LO = 4'd13;
    localparam logic [3:0] IDX_CSUM_HI = 4'd14;
    localparam logic [3:0] IDX_CSUM_LO = 4'd15;

endpackage

FILE: hdl/wcfb_front.sv
// front end: accepts items, keeps frame state and running sum, builds jobs
// depends on wcfb_pkg
module wcfb_front
    import wcfb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     o_in_ready,
    output logic     o_push,
    output t_job     o_job
);

    logic [15:0] r_seq, n_seq;
    logic [15:0] r_hb, n_hb;
    logic [15:0] r_sum, n_sum;
    logic [11:0] r_left, n_left;
    logic        r_open, n_open;

    logic        accept;
    logic        is_hb;
    logic [11:0] len_cnt;
    logic [12:0] len_raw;
    logic [15:0] len_plain;
    logic [15:0] len_word;
    logic [15:0] id_word;
    logic [15:0] hdr_sum;
    logic [15:0] word_sum;
    logic [1:0]  open_status;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // header words and sums
    always_comb begin
        is_hb     = (i_in_item.opcode == OP_HEARTBEAT);
        len_cnt   = is_hb ? 12'd1 : i_in_item.word_count;
        len_raw   = {1'b0, len_cnt} + FIXED_WORDS;
        len_plain = {3'b000, len_raw};
        if (i_cfg.length_check_enable) begin
            len_word = {1'b1, ^len_plain[11:8], ^len_plain[7:4], ^len_plain[3:0],
                        len_plain[11:0]};
        end else begin
            len_word = len_plain;
        end
        id_word     = {i_cfg.address_byte, is_hb ? HEARTBEAT_TYPE : i_cfg.message_type};
        hdr_sum     = len_word + id_word + r_seq + i_cfg.attribute_word;
        word_sum    = r_sum + i_in_item.data_word;
        open_status = r_open ? ST_ABANDON : ST_OK;
    end

    // classify the item and work out the next frame state
    always_comb begin
        o_job.err      = 1'b0;
        o_job.has_hdr  = 1'b0;
        o_job.has_data = 1'b0;
        o_job.has_csum = 1'b0;
        o_job.status   = ST_OK;
        o_job.len      = len_word;
        o_job.id       = id_word;
        o_job.seq      = r_seq;
        o_job.attr     = i_cfg.attribute_word;
        o_job.data     = is_hb ? r_hb : i_in_item.data_word;
        o_job.csum     = hdr_sum;
        o_push         = 1'b0;
        n_seq          = r_seq;
        n_hb           = r_hb;
        n_sum          = r_sum;
        n_left         = r_left;
        n_open         = r_open;
        unique case (i_in_item.opcode)
            OP_START: begin
                o_push         = accept;
                o_job.has_hdr  = 1'b1;
                o_job.has_csum = (i_in_item.word_count == 12'd0);
                o_job.status   = open_status;
                n_seq          = r_seq + 16'd1;
                n_sum          = hdr_sum;
                n_left         = i_in_item.word_count;
                n_open         = (i_in_item.word_count != 12'd0);
            end
            OP_WORD: begin
                o_push = accept;
                if (!r_open) begin
                    o_job.err    = 1'b1;
                    o_job.status = ST_NO_FRAME;
                end else begin
                    o_job.has_data = 1'b1;
                    o_job.has_csum = (r_left == 12'd1);
                    o_job.csum     = word_sum;
                    n_sum          = word_sum;
                    n_left         = r_left - 12'd1;
                    n_open         = (r_left != 12'd1);
                end
            end
            OP_HEARTBEAT: begin
                o_push         = accept;
                o_job.has_hdr  = 1'b1;
                o_job.has_data = 1'b1;
                o_job.has_csum = 1'b1;
                o_job.status   = open_status;
                o_job.csum     = hdr_sum + r_hb;
                n_seq          = r_seq + 16'd1;
                n_hb           = r_hb + 16'd1;
                n_left         = 12'd0;
                n_open         = 1'b0;
            end
            OP_NONE: begin
                o_push = 1'b0;
            end
        endcase
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= 16'd0;
            r_hb   <= 16'd0;
            r_sum  <= 16'd0;
            r_left <= 12'd0;
            r_open <= 1'b0;
        end else if (accept) begin
            r_seq  <= n_seq;
            r_hb   <= n_hb;
            r_sum  <= n_sum;
            r_left <= n_left;
            r_open <= n_open;
        end
    end

endmodule

FILE: hdl/wcfb_queue.sv
// two-entry job queue between front end and serialiser
// depends on wcfb_pkg
module wcfb_queue
    import wcfb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

FILE: hdl/wcfb_back.sv
// back end: serialises jobs into frame bytes through the output register
// depends on wcfb_pkg
module wcfb_back
    import wcfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_q_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_job       r_job;
    logic       r_busy;
    logic [3:0] r_idx;
    logic       r_ov;
    t_out_item  r_out;

    logic       advance;
    logic       last;
    logic [3:0] next_idx;
    logic [3:0] start_idx;
    logic [15:0] cur_word;
    t_out_item  cur_item;

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    // byte selection and sequencing
    always_comb begin
        unique case (r_idx[3:1])
            3'd0, 3'd1: cur_word = {HDR_BYTE, HDR_BYTE};
            3'd2:       cur_word = r_job.len;
            3'd3:       cur_word = r_job.id;
            3'd4:       cur_word = r_job.seq;
            3'd5:       cur_word = r_job.attr;
            3'd6:       cur_word = r_job.data;
            3'd7:       cur_word = r_job.csum;
            default:    cur_word = r_job.csum;
        endcase
        last = r_job.err
            || (r_idx == IDX_CSUM_LO)
            || (r_idx == IDX_DATA_LO && !r_job.has_csum)
            || (r_idx == IDX_HDR_END && !r_job.has_data && !r_job.has_csum);
        next_idx = (r_idx == IDX_HDR_END && !r_job.has_data) ? IDX_CSUM_HI : r_idx + 4'd1;
        start_idx = i_q_job.has_hdr ? IDX_FIRST :
                    (i_q_job.has_data ? IDX_DATA_HI : IDX_CSUM_HI);
        cur_item.out_byte   = r_job.err ? 8'd0 : (r_idx[0] ? cur_word[7:0] : cur_word[15:8]);
        cur_item.run_last   = last;
        cur_item.frame_last = !r_job.err && (r_idx == IDX_CSUM_LO);
        cur_item.status     = r_job.status;
        advance = r_busy && (!r_ov || i_out_ready);
        o_pop   = i_q_valid && (!r_busy || (advance && last));
    end

    // job register and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= IDX_FIRST;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= start_idx;
        end else if (advance && last) begin
            r_busy <= 1'b0;
        end else if (advance) begin
            r_idx <= next_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (advance) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= cur_item;
        end
    end

endmodule

FILE: hdl/word_checksum_frame_builder.sv
// top level of the word checksum frame builder: config registers, front, queue, back
// depends on wcfb_pkg, wcfb_front, wcfb_queue, wcfb_back
//
// Frames leave one byte per cycle through a registered output while the receiver
// is ready. A message word gives two bytes (four when it is the last word and the
// checksum follows), a start item twelve (fourteen when the frame is empty), a
// heartbeat sixteen, a stray word one; a reserved opcode is taken and dropped.
// The front takes one item per cycle while its two-entry job queue has room; the
// serialiser moves to the next job without a gap, so the output byte rate sets
// throughput. Configuration is to be written while idle; the block does not check.
module word_checksum_frame_builder
    import wcfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg r_cfg;
    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_job front_job;
    t_job q_job;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ADDRESS:   r_cfg.address_byte        <= i_cfg_data[7:0];
                CFG_TYPE:      r_cfg.message_type        <= i_cfg_data[7:0];
                CFG_ATTRIBUTE: r_cfg.attribute_word      <= i_cfg_data;
                CFG_LEN_CHECK: r_cfg.length_check_enable <= i_cfg_data[0];
            endcase
        end
    end

    wcfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_job      (front_job)
    );

    wcfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    wcfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: hdl/wcfb_checker.sv
// port-level checks of the frame builder, bound to the top level
// depends on wcfb_pkg and word_checksum_frame_builder_macros.svh
`include "word_checksum_frame_builder_macros.svh"

module wcfb_checker
    import wcfb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // a stalled result item holds
    `WCFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

    // reset empties the output and the queue
    `WCFB_ASSERT_ALWAYS_NEXT(a_reset_clear, i_clk, !i_rst_n, !o_out_valid && o_in_ready)

    // a word outside a frame gives one zero byte that closes its run only
    `WCFB_ASSERT_NOW(a_stray_word, i_clk, i_rst_n, o_out_valid && o_out_item.status == ST_NO_FRAME, o_out_item.run_last && !o_out_item.frame_last && o_out_item.out_byte == 8'd0)

    // the byte that ends a frame also ends its run
    `WCFB_ASSERT_NOW(a_frame_end, i_clk, i_rst_n, o_out_valid && o_out_item.frame_last, o_out_item.run_last && o_out_item.status != ST_NO_FRAME)

endmodule

bind word_checksum_frame_builder wcfb_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
